>>> sv/wpsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the weighted patch scatter accumulator.
// No dependencies; every other file of the block imports this package.
package wpsa_pkg;

   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_PATCH  = 64;

   localparam int SUM_W   = 40;
   localparam int CNT_W   = 16;
   localparam int PROD_W  = 25;
   localparam int DIM_W   = 9;
   localparam int LIM_W   = 13;
   localparam int WADDR_W = 24;

   typedef logic [1:0] func_type;
   localparam func_type FUNC_ACC   = 2'd0;
   localparam func_type FUNC_RD    = 2'd1;
   localparam func_type FUNC_RDCLR = 2'd2;

   typedef logic csr_idx_type;
   localparam csr_idx_type CSR_IMAGE_HEIGHT = 1'b0;
   localparam csr_idx_type CSR_IMAGE_WIDTH  = 1'b1;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [CNT_W-1:0]        CNT_MAX = {CNT_W{1'b1}};

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [CNT_W-1:0]        count;
   } entry_type;

   // Operation in flight between address decode and the store
   typedef struct packed {
      logic                     vld;
      func_type                 func;
      logic                     in_range;
      logic signed [PROD_W-1:0] prod;
   } op_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] weighted_sum;
      logic [CNT_W-1:0]        hit_count;
      logic                    out_of_range;
   } rsp_type;

endpackage

>>> sv/weighted_patch_scatter_accumulator.sv
`timescale 1ns / 1ps
// Top level of the weighted patch scatter accumulator: register port, front
// end, pixel store and result queue. Depends on wpsa_pkg, wpsa_front,
// wpsa_store and wpsa_rsp_fifo.
//
//   channel | handshake              | word
//   --------+------------------------+-----------------------------------------
//   req     | req_valid / req_ready  | func, base/offset col+row, label, weight
//   rsp     | rsp_valid / rsp_ready  | weighted_sum, hit_count, out_of_range
//   csr     | psel/penable/pready    | image_height @0x0, image_width @0x4
//
// One word per cycle is taken while req_ready is high: the memory read is issued
// at acceptance and the update is written back the next cycle, with the last
// write forwarded. A read result passes the op register and is then written
// into the result queue that drives rsp. After reset the store is swept clear
// entry by entry, and req_ready stays low until the sweep is done.
// req_ready also drops when the two-word result queue would overflow.
module weighted_patch_scatter_accumulator #(
   parameter int MAX_HEIGHT = wpsa_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH  = wpsa_pkg::DEF_MAX_WIDTH,
   parameter int MAX_PATCH  = wpsa_pkg::DEF_MAX_PATCH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  wpsa_pkg::func_type                 req_func,
   input  logic [7:0]                         req_base_col,
   input  logic [7:0]                         req_base_row,
   input  logic [5:0]                         req_off_col,
   input  logic [5:0]                         req_off_row,
   input  logic [7:0]                         req_label,
   input  logic signed [15:0]                 req_weight,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [wpsa_pkg::SUM_W-1:0]  rsp_weighted_sum,
   output logic [wpsa_pkg::CNT_W-1:0]         rsp_hit_count,
   output logic                               rsp_out_of_range,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [2:0]                         paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import wpsa_pkg::*;

   localparam int DEPTH  = MAX_HEIGHT * MAX_WIDTH;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DIM_W-1:0]  image_height_ff;
   logic [DIM_W-1:0]  image_height_in;
   logic [DIM_W-1:0]  image_width_ff;
   logic [DIM_W-1:0]  image_width_in;
   logic              csr_wr;
   csr_idx_type       csr_idx;

   logic              accept;
   logic [ADDR_W-1:0] rd_addr;
   op_type            op;
   logic [ADDR_W-1:0] op_addr;
   logic              clear_done;
   logic              res_vld;
   rsp_type           res;
   rsp_type           rsp_word;
   logic [1:0]        q_count;
   logic [2:0]        q_load;
   logic              deq;

   // register port
   always_comb begin
      pready          = 1'b1;
      csr_idx         = csr_idx_type'(paddr[2]);
      csr_wr          = psel && penable && pwrite;
      image_height_in = image_height_ff;
      image_width_in  = image_width_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_IMAGE_HEIGHT: image_height_in = pwdata[DIM_W-1:0];
            CSR_IMAGE_WIDTH:  image_width_in  = pwdata[DIM_W-1:0];
            default:          image_height_in = image_height_ff;
         endcase
      end
      case (csr_idx)
         CSR_IMAGE_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, image_height_ff};
         CSR_IMAGE_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, image_width_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_height_ff <= DIM_W'(256);
         image_width_ff  <= DIM_W'(256);
      end else begin
         image_height_ff <= image_height_in;
         image_width_ff  <= image_width_in;
      end
   end

   // hold the input while queued words plus the one in flight fill the queue and none leaves
   always_comb begin
      deq       = rsp_valid && rsp_ready;
      q_load    = {1'b0, q_count} + {2'b0, op.vld};
      req_ready = clear_done && ((q_load < 3'd2) || (q_load == 3'd2 && deq));
      accept    = req_valid && req_ready;
   end

   wpsa_front #(
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_PATCH  (MAX_PATCH),
      .ADDR_W     (ADDR_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .image_height (image_height_ff),
      .image_width  (image_width_ff),
      .accept       (accept),
      .req_func     (req_func),
      .req_base_col (req_base_col),
      .req_base_row (req_base_row),
      .req_off_col  (req_off_col),
      .req_off_row  (req_off_row),
      .req_label    (req_label),
      .req_weight   (req_weight),
      .rd_addr      (rd_addr),
      .op_ff        (op),
      .op_addr_ff   (op_addr)
   );

   wpsa_store #(
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_WIDTH  (MAX_WIDTH),
      .ADDR_W     (ADDR_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (rd_addr),
      .op         (op),
      .op_addr    (op_addr),
      .clear_done (clear_done),
      .res_vld    (res_vld),
      .res        (res)
   );

   wpsa_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .enq      (res_vld),
      .enq_data (res),
      .deq      (rsp_ready),
      .out_vld  (rsp_valid),
      .out_data (rsp_word),
      .count    (q_count)
   );

   assign rsp_weighted_sum = rsp_word.weighted_sum;
   assign rsp_hit_count    = rsp_word.hit_count;
   assign rsp_out_of_range = rsp_word.out_of_range;

endmodule

>>> sv/wpsa_front.sv
`timescale 1ns / 1ps
// Front end: pixel address, range checks and label*weight product.
// Depends on wpsa_pkg.
module wpsa_front #(
   parameter int MAX_HEIGHT = wpsa_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH  = wpsa_pkg::DEF_MAX_WIDTH,
   parameter int MAX_PATCH  = wpsa_pkg::DEF_MAX_PATCH,
   parameter int ADDR_W     = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [wpsa_pkg::DIM_W-1:0]     image_height,
   input  logic [wpsa_pkg::DIM_W-1:0]     image_width,
   input  logic                           accept,
   input  wpsa_pkg::func_type             req_func,
   input  logic [7:0]                     req_base_col,
   input  logic [7:0]                     req_base_row,
   input  logic [5:0]                     req_off_col,
   input  logic [5:0]                     req_off_row,
   input  logic [7:0]                     req_label,
   input  logic signed [15:0]             req_weight,
   output logic [ADDR_W-1:0]              rd_addr,
   output wpsa_pkg::op_type               op_ff,
   output logic [ADDR_W-1:0]              op_addr_ff
);
   import wpsa_pkg::*;

   localparam logic [LIM_W-1:0]   H_LIM     = LIM_W'(MAX_HEIGHT);
   localparam logic [LIM_W-1:0]   W_LIM     = LIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0]   PATCH_LIM = DIM_W'(MAX_PATCH);
   localparam logic [WADDR_W-1:0] H_MUL     = WADDR_W'(MAX_HEIGHT);

   logic [LIM_W-1:0]         h_eff;
   logic [LIM_W-1:0]         w_eff;
   logic [DIM_W-1:0]         pix_col;
   logic [DIM_W-1:0]         pix_row;
   logic                     off_ok;
   logic                     pix_ok;
   logic [WADDR_W-1:0]       addr_wide;
   logic signed [PROD_W-1:0] prod;
   op_type                   op_in;
   logic [ADDR_W-1:0]        op_addr_in;

   always_comb begin
      h_eff = ({4'b0, image_height} > H_LIM) ? H_LIM : {4'b0, image_height};
      w_eff = ({4'b0, image_width} > W_LIM) ? W_LIM : {4'b0, image_width};
      if (req_func == FUNC_ACC) begin
         pix_col = {1'b0, req_base_col} + {3'b0, req_off_col};
         pix_row = {1'b0, req_base_row} + {3'b0, req_off_row};
         off_ok  = ({3'b0, req_off_col} < PATCH_LIM) && ({3'b0, req_off_row} < PATCH_LIM);
      end else begin
         pix_col = {1'b0, req_base_col};
         pix_row = {1'b0, req_base_row};
         off_ok  = 1'b1;
      end
      pix_ok    = ({4'b0, pix_col} < w_eff) && ({4'b0, pix_row} < h_eff);
      // column-major: entry = col * MAX_HEIGHT + row
      addr_wide = WADDR_W'(pix_col) * H_MUL + WADDR_W'(pix_row);
      rd_addr   = addr_wide[ADDR_W-1:0];
      prod      = PROD_W'($signed({1'b0, req_label}) * req_weight);

      op_in.vld      = accept;
      op_in.func     = req_func;
      op_in.in_range = off_ok && pix_ok;
      op_in.prod     = prod;
      op_addr_in     = rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff.vld <= 1'b0;
      end else begin
         op_ff.vld <= op_in.vld;
      end
      op_ff.func     <= op_in.func;
      op_ff.in_range <= op_in.in_range;
      op_ff.prod     <= op_in.prod;
      op_addr_ff     <= op_addr_in;
   end

endmodule

>>> sv/wpsa_store.sv
`timescale 1ns / 1ps
// Pixel store: sum/count memory, clearing sweep after reset, read-modify-write
// with one-entry write forwarding. Depends on wpsa_pkg.
module wpsa_store #(
   parameter int MAX_HEIGHT = wpsa_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH  = wpsa_pkg::DEF_MAX_WIDTH,
   parameter int ADDR_W     = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [ADDR_W-1:0]   rd_addr,
   input  wpsa_pkg::op_type    op,
   input  logic [ADDR_W-1:0]   op_addr,
   output logic                clear_done,
   output logic                res_vld,
   output wpsa_pkg::rsp_type   res
);
   import wpsa_pkg::*;

   localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
   localparam int CLR_W = ADDR_W + 1;
   localparam logic [CLR_W-1:0] CLR_END = CLR_W'(DEPTH);

   entry_type mem [DEPTH];

   entry_type         rd_data_ff;
   logic [CLR_W-1:0]  clr_cnt_ff;
   logic [CLR_W-1:0]  clr_cnt_in;
   logic              fwd_vld_ff;
   logic              fwd_vld_in;
   logic [ADDR_W-1:0] fwd_addr_ff;
   entry_type         fwd_data_ff;

   entry_type               cur;
   entry_type               upd;
   logic signed [SUM_W:0]   acc;
   logic                    op_we;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_wa;
   entry_type               mem_wd;

   assign clear_done = (clr_cnt_ff == CLR_END);

   always_comb begin
      // take the write of the previous cycle, which the memory read missed
      cur = (fwd_vld_ff && fwd_addr_ff == op_addr) ? fwd_data_ff : rd_data_ff;

      acc = {cur.sum[SUM_W-1], cur.sum} + (SUM_W+1)'(op.prod);
      if (acc[SUM_W] != acc[SUM_W-1]) begin
         upd.sum = acc[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         upd.sum = acc[SUM_W-1:0];
      end
      upd.count = (cur.count == CNT_MAX) ? CNT_MAX : cur.count + 1'b1;

      op_we            = 1'b0;
      mem_wd           = upd;
      res_vld          = 1'b0;
      res.weighted_sum = cur.sum;
      res.hit_count    = cur.count;
      res.out_of_range = 1'b0;
      if (op.vld) begin
         case (op.func)
            FUNC_ACC: begin
               op_we = op.in_range;
            end
            FUNC_RD, FUNC_RDCLR: begin
               res_vld = 1'b1;
               if (op.in_range) begin
                  if (op.func == FUNC_RDCLR) begin
                     op_we  = 1'b1;
                     mem_wd = '0;
                  end
               end else begin
                  res.weighted_sum = '0;
                  res.hit_count    = '0;
                  res.out_of_range = 1'b1;
               end
            end
            default: begin
               op_we = 1'b0;
            end
         endcase
      end

      if (!clear_done) begin
         mem_we     = 1'b1;
         mem_wa     = clr_cnt_ff[ADDR_W-1:0];
         mem_wd     = '0;
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end else begin
         mem_we     = op_we;
         mem_wa     = op_addr;
         clr_cnt_in = clr_cnt_ff;
      end
      fwd_vld_in = op_we;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         fwd_vld_ff <= 1'b0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         fwd_vld_ff <= fwd_vld_in;
      end
      fwd_addr_ff <= op_addr;
      fwd_data_ff <= mem_wd;
   end

endmodule

>>> sv/wpsa_rsp_fifo.sv
`timescale 1ns / 1ps
// Two-word result queue that decouples the store from the result channel.
// Depends on wpsa_pkg.
module wpsa_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               enq,
   input  wpsa_pkg::rsp_type  enq_data,
   input  logic               deq,
   output logic               out_vld,
   output wpsa_pkg::rsp_type  out_data,
   output logic [1:0]         count
);
   import wpsa_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       do_deq;

   always_comb begin
      out_vld   = (cnt_ff != 2'd0);
      out_data  = entry_ff[rd_ptr_ff];
      count     = cnt_ff;
      do_deq    = deq && out_vld;
      wr_ptr_in = enq ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_deq ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, enq} - {1'b0, do_deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (enq) begin
         entry_ff[wr_ptr_ff] <= enq_data;
      end
   end

endmodule
